// ===== rtl/bums_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Merge sort package
// Sizes, element conversions, controller states and the command and status
// words shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package bums_pkg;

	localparam int MAX_ELEMENTS = 64;
	localparam int DATA_WIDTH   = 32;
	localparam int VALUE_W      = 32;
	// store address and loop counter widths
	localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CW = $clog2(MAX_ELEMENTS) + 1;

	typedef logic [DATA_WIDTH-1:0] elem_t;
	typedef logic [CW-1:0]         cnt_t;
	typedef logic [AW-1:0]         addr_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WIDTH,
		ST_RUN,
		ST_MRD,
		ST_MCMP,
		ST_CRD,
		ST_CWR,
		ST_ERD,
		ST_EOUT
	} state_t;

	typedef struct packed {
		logic load;
		logic init_sort;
		logic init_run;
		logic next_width;
		logic setup_merge;
		logic merge_step;
		logic copy_init;
		logic copy_step;
		logic next_run;
		logic emit_init;
		logic emit_step;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic width_le_top;
		logic mid_lt_top;
		logic at_stop;
		logic emit_last;
	} sts_t;

	// input word to element: sign-extend or truncate
	function automatic elem_t to_elem(input logic signed [VALUE_W-1:0] v);
		return DATA_WIDTH'(v);
	endfunction

	// element to output word: zero-extend or truncate
	function automatic logic [VALUE_W-1:0] to_value(input elem_t e);
		return VALUE_W'(e);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/bottom_up_merge_sort.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bottom-up merge sort
// Collects a set of signed words and returns them in ascending order.
// ----------------------------------------------------------------------------
// Input: a word (value, last) is taken at a rising edge with start high and
//   busy low. Words without last are stored as they are taken; busy stays low.
//   The word with last ends the set, starts the sort and raises busy.
// Sort: runs of width 1, 2, 4 ... are merged pairwise into the work store
//   and copied back. Each merged element takes a registered read, then a
//   compare and write, and each copied element a read and a write. The
//   single read-modify loop through the data store sets the pace of the sort.
// Output: each result is read from the store, then shown for one cycle with
//   strobe high, so results never come back to back; final_res marks the
//   greatest, last word and overflow is set on every word if items beyond
//   the store were dropped. The receiver cannot stall; words are never held.
// busy falls in the cycle that shows the final word.
// Reset: asynchronous, active low; clears the element count, the overflow
//   flag, the strobe and the controller. Store contents are not cleared.
// ----------------------------------------------------------------------------
module bottom_up_merge_sort (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [bums_pkg::VALUE_W-1:0] value,
	input  wire logic                          last,
	output logic                               strobe,
	output logic signed [bums_pkg::VALUE_W-1:0] sorted_value,
	output logic                               final_res,
	output logic                               overflow
);
	import bums_pkg::*;

	cmd_t cmd;  // controller -> datapath
	sts_t sts;  // datapath -> controller

	// state machine: load, width loop, run loop, merge, copy-back, emit
	bums_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// stores, counters, comparator and result register
	bums_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.value        (value),
		.sts          (sts),
		.strobe       (strobe),
		.sorted_value (sorted_value),
		.final_res    (final_res),
		.overflow     (overflow)
	);

endmodule
`default_nettype wire

// ===== rtl/bums_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Merge sort controller
// Sequences load, the width and run loops, merge, copy-back and emission.
// ----------------------------------------------------------------------------
module bums_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          last,
	input  wire bums_pkg::sts_t sts,
	output bums_pkg::cmd_t     cmd,
	output logic               busy
);
	import bums_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && last) state_nxt = ST_WIDTH;
			end
			ST_WIDTH: begin
				state_nxt = sts.width_le_top ? ST_RUN : ST_ERD;
			end
			ST_RUN: begin
				state_nxt = sts.mid_lt_top ? ST_MRD : ST_WIDTH;
			end
			ST_MRD:  state_nxt = ST_MCMP;
			ST_MCMP: state_nxt = sts.at_stop ? ST_CRD : ST_MRD;
			ST_CRD:  state_nxt = ST_CWR;
			ST_CWR:  state_nxt = sts.at_stop ? ST_RUN : ST_CRD;
			ST_ERD:  state_nxt = ST_EOUT;
			ST_EOUT: state_nxt = sts.emit_last ? ST_IDLE : ST_ERD;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd  = '0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				cmd.load      = start;
				cmd.init_sort = start && last;
			end
			ST_WIDTH: begin
				cmd.init_run  = sts.width_le_top;
				cmd.emit_init = !sts.width_le_top;
			end
			ST_RUN: begin
				cmd.setup_merge = sts.mid_lt_top;
				cmd.next_width  = !sts.mid_lt_top;
			end
			ST_MCMP: begin
				cmd.merge_step = 1'b1;
				cmd.copy_init  = sts.at_stop;
			end
			ST_CWR: begin
				cmd.copy_step = 1'b1;
				cmd.next_run  = sts.at_stop;
			end
			ST_EOUT: begin
				cmd.emit_step = 1'b1;
				cmd.clear     = sts.emit_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/bums_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Merge sort datapath
// Data and work stores, loop counters, merge compare and result register.
// ----------------------------------------------------------------------------
module bums_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bums_pkg::cmd_t                cmd,
	input  wire logic signed [bums_pkg::VALUE_W-1:0] value,
	output bums_pkg::sts_t                     sts,
	output logic                               strobe,
	output logic signed [bums_pkg::VALUE_W-1:0] sorted_value,
	output logic                               final_res,
	output logic                               overflow
);
	import bums_pkg::*;

	elem_t data_mem [MAX_ELEMENTS];
	elem_t work_mem [MAX_ELEMENTS];

	cnt_t  cnt_q;
	logic  ovf_q;
	logic  strobe_q;
	cnt_t  width_q, start_q, mid_q, stop_q, p_q, q_q, k_q;
	elem_t rd_p_q, rd_q_q, rd_w_q;
	logic [VALUE_W-1:0] out_value_q;
	logic  out_final_q, out_ovf_q;

	cnt_t  top, mid, dbl, run_end, stop_nxt;
	logic  full, take_left;

	assign full     = (cnt_q == CW'(MAX_ELEMENTS));
	assign top      = cnt_q - CW'(1);
	assign mid      = start_q + width_q - CW'(1);
	assign dbl      = width_q << 1;
	assign run_end  = start_q + dbl - CW'(1);
	assign stop_nxt = (run_end > top) ? top : run_end;
	// left run wins ties
	assign take_left = (p_q <= mid_q) &&
		((q_q > stop_q) || ($signed(rd_p_q) <= $signed(rd_q_q)));

	assign sts.width_le_top = (width_q <= top);
	assign sts.mid_lt_top   = (mid < top);
	assign sts.at_stop      = (k_q == stop_q);
	assign sts.emit_last    = (p_q == top);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit_step;
			if (cmd.clear) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (cmd.load) begin
				if (full) ovf_q <= 1'b1;
				else      cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// loop counters
	always_ff @(posedge clk) begin
		if (cmd.init_sort)  width_q <= CW'(1);
		if (cmd.next_width) width_q <= dbl;
		if (cmd.init_run)   start_q <= '0;
		if (cmd.next_run)   start_q <= start_q + dbl;
		if (cmd.setup_merge) begin
			mid_q  <= mid;
			stop_q <= stop_nxt;
			p_q    <= start_q;
			q_q    <= mid + CW'(1);
			k_q    <= start_q;
		end
		if (cmd.merge_step) begin
			if (take_left) p_q <= p_q + CW'(1);
			else           q_q <= q_q + CW'(1);
			// last merged element rewinds k for the copy-back
			if (cmd.copy_init) k_q <= start_q;
			else               k_q <= k_q + CW'(1);
		end
		if (cmd.copy_step) k_q <= k_q + CW'(1);
		if (cmd.emit_init) p_q <= '0;
		if (cmd.emit_step) p_q <= p_q + CW'(1);
	end

	// data store: one write, two registered reads
	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			data_mem[cnt_q[AW-1:0]] <= to_elem(value);
		end else if (cmd.copy_step) begin
			data_mem[k_q[AW-1:0]] <= rd_w_q;
		end
		rd_p_q <= data_mem[p_q[AW-1:0]];
		rd_q_q <= data_mem[q_q[AW-1:0]];
	end

	// work store
	always_ff @(posedge clk) begin
		if (cmd.merge_step) begin
			work_mem[k_q[AW-1:0]] <= take_left ? rd_p_q : rd_q_q;
		end
		rd_w_q <= work_mem[k_q[AW-1:0]];
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.emit_step) begin
			out_value_q <= to_value(rd_p_q);
			out_final_q <= sts.emit_last;
			out_ovf_q   <= ovf_q;
		end
	end

	assign strobe       = strobe_q;
	assign sorted_value = $signed(out_value_q);
	assign final_res    = out_final_q;
	assign overflow     = out_ovf_q;

endmodule
`default_nettype wire

// ===== rtl/bums_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Merge sort port checker
// Watches the top-level ports for sequencing errors.
// ----------------------------------------------------------------------------
module bums_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic signed [bums_pkg::VALUE_W-1:0] value,
	input wire logic                          last,
	input wire logic                          strobe,
	input wire logic signed [bums_pkg::VALUE_W-1:0] sorted_value,
	input wire logic                          final_res,
	input wire logic                          overflow
);
	// a word that closes a set makes the block busy
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last |=> busy)
		else $error("busy not raised after set end");

	// a plain load produces no result
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !last |=> !strobe)
		else $error("result after non-final load");

	// more results follow a non-final one, so the block stays busy
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !final_res |-> busy)
		else $error("idle during emission");

	// results never come back to back
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !final_res |=> !strobe)
		else $error("back-to-back results");

	// the final word leaves the block idle
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && final_res |-> !busy)
		else $error("busy with final word");

endmodule

bind bottom_up_merge_sort bums_chk u_bums_chk (.*);
`default_nettype wire
